/* rtl/mkd_pkg.sv */
// Shared types, constants and the Morse tree table for the key decoder.
`timescale 1ns / 1ps

package mkd_pkg;

  // Configuration register indexes and port widths.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 1'd1;

  // Register reset values.
  localparam logic [7:0] DASH_THRESHOLD_RST = 8'd5;
  localparam logic [3:0] GAP_TICKS_RST      = 4'd8;

  // Field widths and limits.
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned GAP_W    = 4;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned LETTER_W = 7;
  localparam logic [HOLD_W-1:0]   HOLD_MAX    = '1;
  localparam logic [INDEX_W-1:0]  INDEX_ROOT  = 5'd1;
  localparam logic [LETTER_W-1:0] SPACE_CODE  = 7'h20;
  localparam logic [LETTER_W-1:0] EMPTY_SLOT  = 7'h00;

  // Kind of event reported for one tick.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DOT    = 2'd1,
    EV_DASH   = 2'd2,
    EV_LETTER = 2'd3
  } event_kind_t;

  // Decoder state carried from tick to tick.
  typedef struct packed {
    logic [HOLD_W-1:0]  hold_count;
    logic [GAP_W-1:0]   gap_count;
    logic [INDEX_W-1:0] tree_index;
    logic               index_overflow;
  } dec_state_t;

  // Configuration as seen by the step logic.
  typedef struct packed {
    logic [HOLD_W-1:0] dash_threshold;
    logic [GAP_W-1:0]  gap_ticks;
  } dec_cfg_t;

  // One result item.
  typedef struct packed {
    event_kind_t         event_kind;
    logic [LETTER_W-1:0] letter_code;
    logic                bad_code;
    logic                lamp_on;
  } dec_result_t;

  // Implicit binary Morse tree: a zero entry marks an empty slot.
  function automatic logic [LETTER_W-1:0] tree_letter(input logic [INDEX_W-1:0] idx);
    logic [LETTER_W-1:0] ch;
    begin
      unique case (idx)
        5'd1:    ch = 7'h20; // ' '
        5'd2:    ch = 7'h65; // e
        5'd3:    ch = 7'h74; // t
        5'd4:    ch = 7'h69; // i
        5'd5:    ch = 7'h61; // a
        5'd6:    ch = 7'h6e; // n
        5'd7:    ch = 7'h6d; // m
        5'd8:    ch = 7'h73; // s
        5'd9:    ch = 7'h75; // u
        5'd10:   ch = 7'h72; // r
        5'd11:   ch = 7'h77; // w
        5'd12:   ch = 7'h64; // d
        5'd13:   ch = 7'h6b; // k
        5'd14:   ch = 7'h67; // g
        5'd15:   ch = 7'h6f; // o
        5'd16:   ch = 7'h68; // h
        5'd17:   ch = 7'h76; // v
        5'd18:   ch = 7'h66; // f
        5'd20:   ch = 7'h6c; // l
        5'd22:   ch = 7'h70; // p
        5'd23:   ch = 7'h6a; // j
        5'd24:   ch = 7'h62; // b
        5'd25:   ch = 7'h78; // x
        5'd26:   ch = 7'h63; // c
        5'd27:   ch = 7'h79; // y
        5'd28:   ch = 7'h7a; // z
        5'd29:   ch = 7'h71; // q
        default: ch = EMPTY_SLOT;
      endcase
      return ch;
    end
  endfunction

endpackage

/* rtl/mkd_chan_if.sv */
// Valid/ready channel interfaces for key samples and decoder results.
`timescale 1ns / 1ps

// Key sample channel.
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink   (input valid, input key_down, output ready);
endinterface

// Decoder result channel.
interface mkd_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_kind;
  logic [mkd_pkg::LETTER_W-1:0]  letter_code;
  logic                          bad_code;
  logic                          lamp_on;

  modport source (output valid, output event_kind, output letter_code,
                  output bad_code, output lamp_on, input ready);
  modport sink   (input valid, input event_kind, input letter_code,
                  input bad_code, input lamp_on, output ready);
endinterface

/* rtl/mkd_step.sv */
// Per-tick decode logic: next decoder state and the result for one key sample.
`timescale 1ns / 1ps

module mkd_step (
  input  mkd_pkg::dec_cfg_t    cfg,
  input  mkd_pkg::dec_state_t  state,
  input  logic                 key_down,
  output mkd_pkg::dec_state_t  state_next,
  output mkd_pkg::dec_result_t result
);

  logic [mkd_pkg::GAP_W-1:0]    gap_limit;
  logic [mkd_pkg::GAP_W-1:0]    gap_inc;
  logic                         is_dash;
  logic [mkd_pkg::INDEX_W-1:0]  walk_index;
  logic                         walk_overflow;
  logic [mkd_pkg::LETTER_W-1:0] slot_letter;

  // A zero gap setting behaves as one tick.
  assign gap_limit = (cfg.gap_ticks == '0) ? 4'd1 : cfg.gap_ticks;
  assign gap_inc   = state.gap_count + 4'd1;
  assign is_dash   = (state.hold_count >= cfg.dash_threshold);

  // Tree walk on release: a fifth symbol only marks overflow.
  always_comb begin
    walk_index    = state.tree_index;
    walk_overflow = state.index_overflow;
    if (!key_down && state.hold_count != '0) begin
      if (state.tree_index[mkd_pkg::INDEX_W-1]) begin
        walk_overflow = 1'b1;
      end else begin
        walk_index = {state.tree_index[mkd_pkg::INDEX_W-2:0], is_dash};
      end
    end
  end

  assign slot_letter = mkd_pkg::tree_letter(walk_index);

  // Counter updates and the reported event.
  always_comb begin
    state_next         = state;
    result.event_kind  = mkd_pkg::EV_NONE;
    result.letter_code = '0;
    result.bad_code    = 1'b0;
    result.lamp_on     = key_down;
    if (key_down) begin
      state_next.gap_count = '0;
      if (state.hold_count != mkd_pkg::HOLD_MAX) begin
        state_next.hold_count = state.hold_count + 8'd1;
      end
    end else begin
      if (state.hold_count != '0) begin
        result.event_kind = is_dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT;
      end
      state_next.hold_count     = '0;
      state_next.tree_index     = walk_index;
      state_next.index_overflow = walk_overflow;
      state_next.gap_count      = gap_inc;
      // End of a letter: report it and return to the root.
      if (gap_inc >= gap_limit) begin
        result.event_kind = mkd_pkg::EV_LETTER;
        result.lamp_on    = 1'b1;
        if (walk_overflow || slot_letter == mkd_pkg::EMPTY_SLOT) begin
          result.letter_code = mkd_pkg::SPACE_CODE;
          result.bad_code    = 1'b1;
        end else begin
          result.letter_code = slot_letter;
        end
        state_next.tree_index     = mkd_pkg::INDEX_ROOT;
        state_next.index_overflow = 1'b0;
        state_next.gap_count      = '0;
      end
    end
  end

endmodule

/* rtl/morse_key_decoder.sv */
// Top level of the Morse key decoder: configuration, state and result register.
`timescale 1ns / 1ps

// The decoder takes one key sample per transaction and returns exactly one
// result transaction for it: none, dot, dash or a decoded letter, plus the
// lamp level. Each sample is decoded combinationally by the step logic and
// its result lands in one output register, so a new sample is accepted in
// every cycle while the output side takes results; the sample channel stalls
// only while that output register is full and not being taken. Configuration
// writes take effect at once and are meant for idle periods.
module morse_key_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]   cfg_data,
  mkd_key_if.sink                          key_ch,
  mkd_res_if.source                        res_ch
);

  mkd_pkg::dec_cfg_t    cfg;
  mkd_pkg::dec_state_t  state;
  mkd_pkg::dec_state_t  state_next;
  mkd_pkg::dec_result_t step_result;
  mkd_pkg::dec_result_t res_reg;
  logic                 res_valid;
  logic                 key_accept;

  // A sample is taken whenever the result register is free or draining.
  assign key_ch.ready = !res_valid || res_ch.ready;
  assign key_accept   = key_ch.valid && key_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_threshold <= mkd_pkg::DASH_THRESHOLD_RST;
      cfg.gap_ticks      <= mkd_pkg::GAP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkd_pkg::REG_DASH_THRESHOLD: cfg.dash_threshold <= cfg_data;
        mkd_pkg::REG_GAP_TICKS:      cfg.gap_ticks      <= cfg_data[mkd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  mkd_step u_step (
    .cfg        (cfg),
    .state      (state),
    .key_down   (key_ch.key_down),
    .state_next (state_next),
    .result     (step_result)
  );

  // Decoder state advances once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.hold_count     <= '0;
      state.gap_count      <= '0;
      state.tree_index     <= mkd_pkg::INDEX_ROOT;
      state.index_overflow <= 1'b0;
    end else if (key_accept) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (key_accept) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_accept) begin
      res_reg <= step_result;
    end
  end

  assign res_ch.valid       = res_valid;
  assign res_ch.event_kind  = res_reg.event_kind;
  assign res_ch.letter_code = res_reg.letter_code;
  assign res_ch.bad_code    = res_reg.bad_code;
  assign res_ch.lamp_on     = res_reg.lamp_on;

endmodule

/* rtl/mkd_checker.sv */
// Port-level assertions for the Morse key decoder and their bind.
`timescale 1ns / 1ps

module mkd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [1:0]                      event_kind,
  input logic [mkd_pkg::LETTER_W-1:0]    letter_code,
  input logic                            bad_code,
  input logic                            lamp_on
);

  // No result is offered right after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // A letter always lights the lamp.
  a_letter_lamp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_kind == mkd_pkg::EV_LETTER) |-> lamp_on)
    else $error("letter reported with lamp off");

  // Letter fields stay clear on events other than a letter.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_kind != mkd_pkg::EV_LETTER) |-> (letter_code == '0 && !bad_code))
    else $error("letter fields set on a non-letter event");

  // A bad code is always reported as a space.
  a_bad_is_space: assert property (@(posedge clk) disable iff (rst)
    (res_valid && bad_code) |-> (letter_code == mkd_pkg::SPACE_CODE))
    else $error("bad code without a space");

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(event_kind) && $stable(letter_code) &&
       $stable(bad_code) && $stable(lamp_on)))
    else $error("stalled result changed");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_ch.valid),
  .res_ready   (res_ch.ready),
  .event_kind  (res_ch.event_kind),
  .letter_code (res_ch.letter_code),
  .bad_code    (res_ch.bad_code),
  .lamp_on     (res_ch.lamp_on)
);

/* bench/morse_key_decoder_test.sv */
// Self-checking bench for the Morse key decoder, with random key timing and a tick-level predictor.
`timescale 1ns / 1ps

module morse_key_decoder_test;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;

  // Letters of the implicit Morse tree; a zero marks a slot with no letter.
  localparam logic [7:0] MORSE_TREE [0:31] = '{
    8'h00, " ", "e", "t", "i", "a", "n", "m",
    "s", "u", "r", "w", "d", "k", "g", "o",
    "h", "v", "f", 8'h00, "l", 8'h00, "p", "j",
    "b", "x", "c", "y", "z", "q", 8'h00, 8'h00
  };

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mkd_pkg::CFG_DATA_W-1:0] cfg_data;

  mkd_key_if key_ch ();
  mkd_res_if res_ch ();

  morse_key_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_ch    (key_ch),
    .res_ch    (res_ch)
  );

  // Predictor copy of the decoder configuration and state.
  logic [mkd_pkg::HOLD_W-1:0]  dash_min;
  logic [mkd_pkg::GAP_W-1:0]   gap_len;
  logic [mkd_pkg::HOLD_W-1:0]  held_ticks;
  logic [mkd_pkg::GAP_W-1:0]   quiet_ticks;
  logic [mkd_pkg::INDEX_W-1:0] node;
  logic                        node_overflow;

  // Key samples waiting to be sent and decoder events waiting to come back.
  logic                 key_samples [$];
  mkd_pkg::dec_result_t awaited_events [$];
  int                   samples_queued;
  int                   samples_taken;

  bit key_taken;
  bit res_taken;
  bit key_pauses;
  bit res_pauses;
  bit failed;
  int key_wait;
  int res_wait;
  int hold_left;
  int hold_off_asked;
  int hold_off_done;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the predictor by one key sample and return the event it reports.
  function automatic mkd_pkg::dec_result_t decode_tick(input logic key);
    mkd_pkg::dec_result_t      r;
    logic [mkd_pkg::GAP_W-1:0] limit;
    logic                      is_dash;
    logic [7:0]                ch;
    r.event_kind  = mkd_pkg::EV_NONE;
    r.letter_code = '0;
    r.bad_code    = 1'b0;
    r.lamp_on     = key;
    if (key) begin
      quiet_ticks = '0;
      if (held_ticks != mkd_pkg::HOLD_MAX) held_ticks = held_ticks + 1'b1;
    end else begin
      limit = (gap_len == '0) ? 4'd1 : gap_len;
      // A release closes the press as a dot or a dash.
      if (held_ticks != '0) begin
        is_dash = (held_ticks >= dash_min);
        r.event_kind = is_dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT;
        if (node >= 5'd16) node_overflow = 1'b1;
        else node = {node[mkd_pkg::INDEX_W-2:0], is_dash};
        held_ticks = '0;
      end
      quiet_ticks = quiet_ticks + 1'b1;
      // Enough silence ends the letter and returns the walk to the root.
      if (quiet_ticks >= limit) begin
        ch = MORSE_TREE[node];
        r.event_kind = mkd_pkg::EV_LETTER;
        r.lamp_on    = 1'b1;
        if (node_overflow || ch == 8'h00) begin
          r.letter_code = mkd_pkg::SPACE_CODE;
          r.bad_code    = 1'b1;
        end else begin
          r.letter_code = ch[mkd_pkg::LETTER_W-1:0];
        end
        node          = mkd_pkg::INDEX_ROOT;
        node_overflow = 1'b0;
        quiet_ticks   = '0;
      end
    end
    return r;
  endfunction

  // Idle cycles before the next offer or the next ready; often none.
  function automatic int draw_wait(input bit enabled);
    if (!enabled) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      failed = 1'b1;
    end
  endfunction

  // Sample driver: offers queued key samples with random pauses after each transaction.
  always @(negedge clk) begin : key_driver
    if (rst) begin
      key_ch.valid <= 1'b0;
      key_wait     <= 0;
    end else if (key_ch.valid && !key_taken) begin
      // The offered sample stays put until it is taken.
    end else if (key_wait > 0) begin
      key_ch.valid <= 1'b0;
      key_wait     <= key_wait - 1;
    end else if (key_samples.size() > 0) begin
      key_ch.valid    <= 1'b1;
      key_ch.key_down <= key_samples.pop_front();
      key_wait        <= draw_wait(key_pauses);
    end else begin
      key_ch.valid <= 1'b0;
    end
  end

  // Result sink: random ready gaps, plus a long hold-off on request.
  always @(negedge clk) begin : result_sink
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_wait     <= 0;
      hold_left    <= 0;
    end else if (hold_off_asked != hold_off_done) begin
      res_ch.ready  <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      hold_off_done <= hold_off_asked;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (res_ch.ready && !res_taken) begin
      // Keep ready up until a result is taken.
    end else if (res_wait > 0) begin
      res_ch.ready <= 1'b0;
      res_wait     <= res_wait - 1;
    end else begin
      res_ch.ready <= 1'b1;
      res_wait     <= draw_wait(res_pauses);
    end
  end

  // Monitor: checks each result against the oldest awaited event, then predicts new samples.
  always @(posedge clk) begin : tick_monitor
    mkd_pkg::dec_result_t want;
    if (rst) begin
      key_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      key_taken <= key_ch.valid && key_ch.ready;
      res_taken <= res_ch.valid && res_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_events.size() == 0) begin
          $error("result with nothing awaited: event_kind %0d", res_ch.event_kind);
          failed = 1'b1;
        end else begin
          want = awaited_events.pop_front();
          check_field("event_kind", want.event_kind, res_ch.event_kind);
          check_field("letter_code", want.letter_code, res_ch.letter_code);
          check_field("bad_code", want.bad_code, res_ch.bad_code);
          check_field("lamp_on", want.lamp_on, res_ch.lamp_on);
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        awaited_events.push_back(decode_tick(key_ch.key_down));
        samples_taken++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin : watchdog
    if (rst || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write while the decoder is idle; the predictor follows it.
  task automatic write_reg(input logic [mkd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mkd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mkd_pkg::REG_DASH_THRESHOLD) dash_min = data;
    else gap_len = data[mkd_pkg::GAP_W-1:0];
    @(posedge clk);
    #1;
  endtask

  task automatic wait_drained();
    while (samples_taken != samples_queued || awaited_events.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic queue_run(input logic level, input int count);
    repeat (count) key_samples.push_back(level);
    samples_queued += count;
  endtask

  task automatic queue_noise(input int count);
    repeat (count) queue_run(1'($urandom_range(0, 1)), 1);
  endtask

  // Press length for a dot or a dash, hitting the threshold boundary now and then.
  function automatic int press_ticks(input logic dash);
    int thr;
    thr = int'(dash_min);
    if (dash) return (thr == 0) ? $urandom_range(1, 3) : thr + $urandom_range(0, 2);
    if (thr <= 1) return 1;
    if ($urandom_range(0, 3) == 0) return thr - 1;
    return $urandom_range(1, (thr - 1 > 6) ? 6 : thr - 1);
  endfunction

  // A letter: symbols taken from the low bits of pattern, first symbol highest, then the gap.
  task automatic queue_letter(input logic [5:0] pattern, input int count);
    int g;
    g = (gap_len == '0) ? 1 : int'(gap_len);
    for (int i = count - 1; i >= 0; i--) begin
      queue_run(1'b1, press_ticks(pattern[i]));
      if (i > 0) queue_run(1'b0, (g > 1) ? $urandom_range(1, g - 1) : 1);
    end
    queue_run(1'b0, g);
  endtask

  initial begin : stimulus
    int start;
    int n;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = mkd_pkg::REG_DASH_THRESHOLD;
    cfg_data        = '0;
    key_ch.valid    = 1'b0;
    key_ch.key_down = 1'b0;
    res_ch.ready    = 1'b0;
    dash_min        = mkd_pkg::DASH_THRESHOLD_RST;
    gap_len         = mkd_pkg::GAP_TICKS_RST;
    held_ticks      = '0;
    quiet_ticks     = '0;
    node            = mkd_pkg::INDEX_ROOT;
    node_overflow   = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // Reset settings: a dot one tick short of the threshold, then a dash right on it.
    key_pauses = 1'b1;
    res_pauses = 1'b1;
    queue_run(1'b1, 4);
    queue_run(1'b0, 2);
    queue_run(1'b1, 5);
    queue_run(1'b0, 8);
    wait_drained();

    // An empty tree slot, too many symbols and silence at the root.
    write_reg(mkd_pkg::REG_DASH_THRESHOLD, 8'd2);
    write_reg(mkd_pkg::REG_GAP_TICKS, 8'hA3);
    queue_letter(6'b000011, 4);
    queue_letter(6'b001111, 4);
    queue_letter(6'b011111, 5);
    queue_letter(6'b000000, 0);
    queue_run(1'b0, 6);
    wait_drained();

    // Zero threshold and zero gap: every press a dash, every release a letter.
    write_reg(mkd_pkg::REG_DASH_THRESHOLD, 8'h00);
    write_reg(mkd_pkg::REG_GAP_TICKS, 8'h50);
    queue_noise(12);
    queue_letter(6'($urandom), 3);
    wait_drained();

    // Smallest legal settings: the symbol and the letter land on one tick.
    res_pauses = 1'b0;
    write_reg(mkd_pkg::REG_DASH_THRESHOLD, 8'd1);
    write_reg(mkd_pkg::REG_GAP_TICKS, 8'd1);
    queue_noise(16);
    wait_drained();

    // Largest settings: a press long enough to saturate the hold count.
    key_pauses = 1'b0;
    res_pauses = 1'b1;
    write_reg(mkd_pkg::REG_DASH_THRESHOLD, 8'hFF);
    write_reg(mkd_pkg::REG_GAP_TICKS, 8'hFF);
    queue_run(1'b1, 257);
    queue_run(1'b0, 15);
    wait_drained();

    // Random settings with mostly well-formed letters and some key noise.
    for (int p = 0; p < 4; p++) begin
      write_reg(mkd_pkg::REG_DASH_THRESHOLD, 8'($urandom_range(1, 8)));
      write_reg(mkd_pkg::REG_GAP_TICKS, 8'($urandom_range(1, 12) + 16 * $urandom_range(0, 15)));
      key_pauses = p[0];
      res_pauses = p[1];
      // One phase stalls the result side for a long stretch, and the samples stall with it.
      if (p == 2) hold_off_asked++;
      start = samples_queued;
      while (samples_queued - start < 10) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_noise($urandom_range(3, 10));
        end else begin
          n = $urandom_range(0, 9);
          n = (n == 0) ? 0 : (n >= 8) ? n - 3 : (n - 1) % 4 + 1;
          queue_letter(6'($urandom), n);
        end
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mkd_pkg.sv
rtl/mkd_chan_if.sv
rtl/mkd_step.sv
rtl/morse_key_decoder.sv
rtl/mkd_checker.sv
bench/morse_key_decoder_test.sv
